[design/assert_macros.svh]
// Assertion macros used by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/rgam_pkg.sv]
// Types and constants of the ramped-gain audio mixer.
`timescale 1ns / 1ps
`default_nettype none

package rgam_pkg;

  typedef enum logic [1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_SAMPLE     = 2'd2
  } cmd_e;

  localparam int GainStep  = 4096;
  localparam int UnityGain = 65536;

  // result queue
  localparam int OutDepth = 4;
  localparam int OutPtrW  = 2;
  localparam int OutCntW  = 3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [3:0]          channel;
    logic signed [31:0]  target_gain;
    logic signed [15:0]  sample;
    logic [6:0]          sample_index;
    logic                first_channel;
    logic                final_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  mixed_sample;
    logic [6:0]          out_index;
    logic                block_end;
  } out_item_t;

endpackage

`default_nettype wire

[design/ramped_gain_audio_mixer_unit.sv]
// Top level of the ramped-gain audio mixer: gain store, multiply, mix memory, result queue.
// A sample item passes the stage 1 and stage 2 registers before it is written into the result queue.
// Throughput: one item per cycle while in_stall_o is low; the mix memory read-modify-write is pipelined
//   with forwarding between back-to-back items on the same position.
// Set-target and tick items take effect on the cycle after acceptance.
// Reset: gains go to unity, pipeline and result queue empty; mix memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ramped_gain_audio_mixer_unit
  import rgam_pkg::*;
#(
  parameter int CHANNELS      = 4,
  parameter int BLOCK_SAMPLES = 128
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW   = $clog2(BLOCK_SAMPLES);
  // wide enough to hold BLOCK_SAMPLES itself and any 7-bit index
  localparam int IdxW = (AW + 1 > 8) ? AW + 1 : 8;

  // Gain ramp: step toward the target, landing exactly on it when the step
  // would pass it.
  function automatic logic signed [31:0] ramp_step(input logic signed [31:0] g,
                                                   input logic signed [31:0] w);
    logic signed [32:0] up;
    logic signed [32:0] dn;
    logic signed [32:0] w33;
    logic signed [31:0] r;
    up  = 33'(g) + 33'(GainStep);
    dn  = 33'(g) - 33'(GainStep);
    w33 = 33'(w);
    if (g < w) begin
      r = (up > w33) ? w : up[31:0];
    end else if (g > w) begin
      r = (dn < w33) ? w : dn[31:0];
    end else begin
      r = g;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  logic            in_acc;
  logic            ch_ok;
  logic            idx_ok;
  logic [IdxW-1:0] idx_ext;
  logic [ChW-1:0]  ch_sel;
  logic            samp_go;
  logic            set_go;
  logic            tick_go;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign ch_ok   = {1'b0, in_item_i.channel} < 5'(CHANNELS);
  assign idx_ext = IdxW'(in_item_i.sample_index);
  assign idx_ok  = idx_ext < IdxW'(BLOCK_SAMPLES);
  assign ch_sel  = in_item_i.channel[ChW-1:0];

  always_comb begin
    samp_go = 1'b0;
    set_go  = 1'b0;
    tick_go = 1'b0;
    case (in_item_i.cmd)
      CMD_SET_TARGET: set_go  = in_acc && ch_ok;
      CMD_TICK:       tick_go = in_acc;
      CMD_SAMPLE:     samp_go = in_acc && ch_ok && idx_ok;
      default: ;  // unused code, no effect
    endcase
  end

  // ---------------------------------------------------------------------
  // Gain store: current and target registers per channel; the tick ramps every
  // current gain at once, the sample path reads the selected channel at acceptance.
  // ---------------------------------------------------------------------
  logic signed [31:0] cur_gain_q  [CHANNELS];
  logic signed [31:0] want_gain_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cur_gain_q[c]  <= 32'(UnityGain);
        want_gain_q[c] <= 32'(UnityGain);
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (tick_go) begin
          cur_gain_q[c] <= ramp_step(cur_gain_q[c], want_gain_q[c]);
        end
        if (set_go && (ch_sel == ChW'(c))) begin
          want_gain_q[c] <= in_item_i.target_gain;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: gain and sample registered; multiply and mix memory read here.
  // ---------------------------------------------------------------------
  logic               s1_vld_q, s1_emit_q;
  logic               s1_first_q, s1_end_q;
  logic signed [31:0] s1_gain_q;
  logic signed [15:0] s1_smp_q;
  logic [AW-1:0]      s1_addr_q;
  logic [6:0]         s1_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_emit_q <= 1'b0;
    end else begin
      s1_vld_q  <= samp_go;
      s1_emit_q <= samp_go && in_item_i.final_channel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (samp_go) begin
      s1_gain_q  <= cur_gain_q[ch_sel];
      s1_smp_q   <= in_item_i.sample;
      s1_addr_q  <= idx_ext[AW-1:0];
      s1_idx_q   <= in_item_i.sample_index;
      s1_first_q <= in_item_i.first_channel;
      s1_end_q   <= idx_ext == IdxW'(BLOCK_SAMPLES - 1);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: scale, saturate, mix, write back and queue the result.
  // ---------------------------------------------------------------------
  logic               s2_vld_q, s2_emit_q;
  logic               s2_first_q, s2_end_q;
  logic signed [47:0] s2_prod_d, s2_prod_q;
  logic [AW-1:0]      s2_addr_q;
  logic [6:0]         s2_idx_q;
  logic               fwd_hit_d, fwd_hit_q;
  logic signed [15:0] fwd_data_q;
  logic signed [15:0] rd_data_q;

  logic signed [15:0] mix_mem [BLOCK_SAMPLES];

  assign s2_prod_d = s1_gain_q * s1_smp_q;

  logic               prod_fits;
  logic signed [15:0] scaled;
  logic signed [15:0] prior;
  logic signed [16:0] sum17;
  logic signed [15:0] added;
  logic signed [15:0] mixed;

  always_comb begin
    // gain*sample >> 16 fits 16 bits when the top 17 product bits agree
    prod_fits = (&s2_prod_q[47:31]) || !(|s2_prod_q[47:31]);
    if (prod_fits) begin
      scaled = s2_prod_q[31:16];
    end else begin
      scaled = s2_prod_q[47] ? 16'sh8000 : 16'sh7fff;
    end
    // item just ahead wrote this position while our read was in flight
    prior = fwd_hit_q ? fwd_data_q : rd_data_q;
    sum17 = {prior[15], prior} + {scaled[15], scaled};
    if (sum17[16] != sum17[15]) begin
      added = sum17[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      added = sum17[15:0];
    end
    mixed = s2_first_q ? scaled : added;
  end

  assign fwd_hit_d = s2_vld_q && s1_vld_q && (s1_addr_q == s2_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s2_emit_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      s2_vld_q  <= s1_vld_q;
      s2_emit_q <= s1_emit_q;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_prod_q  <= s2_prod_d;
      s2_addr_q  <= s1_addr_q;
      s2_idx_q   <= s1_idx_q;
      s2_first_q <= s1_first_q;
      s2_end_q   <= s1_end_q;
    end
    fwd_data_q <= mixed;
  end

  // mix memory: one write port (stage 2), one registered read port (stage 1)
  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      mix_mem[s2_addr_q] <= mixed;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mix_mem[s1_addr_q];
  end

  // ---------------------------------------------------------------------
  // Result queue. Input stalls when queued results plus those in flight
  // could fill it, so the pipeline itself never has to halt.
  // ---------------------------------------------------------------------
  out_item_t           oq_q [OutDepth];
  logic [OutPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]  cnt_d, cnt_q;
  logic                push, pop;
  logic [OutCntW:0]    pending;

  assign push = s2_vld_q && s2_emit_q;
  assign pop  = out_valid_o && !out_stall_i;

  assign pending    = (OutCntW + 1)'(cnt_q) + (OutCntW + 1)'(s1_emit_q)
                    + (OutCntW + 1)'(s2_emit_q);
  assign in_stall_o = pending >= (OutCntW + 1)'(OutDepth);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[wr_ptr_q] <= '{mixed_sample: mixed, out_index: s2_idx_q, block_end: s2_end_q};
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = oq_q[rd_ptr_q];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_RST(a_oq_bound, clk_i, rst_ni, cnt_q <= OutCntW'(OutDepth),
    "result queue count beyond depth")
  `ASSERT_RST(a_credit, clk_i, rst_ni,
    pending <= (OutCntW + 1)'(OutDepth),
    "queued plus in-flight results exceed queue depth")
  `ASSERT_RST(a_fwd_src, clk_i, rst_ni,
    fwd_hit_q |-> $past(s2_vld_q && s1_vld_q),
    "forward hit without two back-to-back samples")
  `ASSERT_RST(a_push_room, clk_i, rst_ni,
    push |-> (cnt_q < OutCntW'(OutDepth)) || pop,
    "result pushed into a full queue")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Testbench of the ramped-gain audio mixer: gain and mix predictor, directed table, random blocks.
`timescale 1ns / 1ps

module testbench;
  import rgam_pkg::*;

  localparam int NCH   = 4;
  localparam int NSAMP = 128;

  // cmd code 3 has no meaning; the block must ignore it
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic signed [31:0] GainMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] GainMin = 32'sh8000_0000;

  // -------------------------------------------------------------------------
  // Clock, reset and block ports. Every input holds a known value from time 0.
  // -------------------------------------------------------------------------
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  always #1 clk_i = ~clk_i;

  ramped_gain_audio_mixer_unit #(
    .CHANNELS     (NCH),
    .BLOCK_SAMPLES(NSAMP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // -------------------------------------------------------------------------
  // Predictor state: gains per channel and the mix memory. The written flags
  // keep the stimulus from ever adding to or emitting an unwritten entry.
  // -------------------------------------------------------------------------
  logic signed [31:0] cur_gain [NCH];
  logic signed [31:0] tgt_gain [NCH];
  logic signed [15:0] mix_mem  [NSAMP];
  bit                 mix_written [NSAMP];

  out_item_t expected_mix[$];
  int        mismatch_count = 0;
  int        live_items     = 0;

  // idle rates of the current phase, in percent
  int send_idle_pct = 0;
  int stall_pct     = 0;

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Block tick: each gain moves one step toward its target. Landing past the
  // target, or past the 32-bit limits, clamps onto the target itself.
  function automatic void step_gains();
    longint g, w;
    for (int c = 0; c < NCH; c++) begin
      g = cur_gain[c];
      w = tgt_gain[c];
      if (g < w) begin
        g = g + GainStep;
        if (g > w) g = w;
      end else if (g > w) begin
        g = g - GainStep;
        if (g < w) g = w;
      end
      cur_gain[c] = 32'(g);
    end
  endfunction

  // Applies one accepted item to the predictor; returns 1 with the mixed
  // result when the item emits one.
  function automatic bit predict_mix(input in_item_t it, output out_item_t res);
    longint             prod;
    logic signed [15:0] scaled, mixed;
    res = '0;
    case (it.cmd)
      CMD_SET_TARGET: begin
        if (it.channel < NCH) tgt_gain[it.channel] = it.target_gain;
      end
      CMD_TICK: begin
        step_gains();
      end
      CMD_SAMPLE: begin
        if (it.channel < NCH && it.sample_index < NSAMP) begin
          // 48-bit product, arithmetic shift gives the floor of /65536
          prod   = longint'(cur_gain[it.channel]) * longint'(it.sample);
          scaled = clip16(prod >>> 16);
          if (it.first_channel) mixed = scaled;
          else mixed = clip16(longint'(mix_mem[it.sample_index]) + longint'(scaled));
          mix_mem[it.sample_index]     = mixed;
          mix_written[it.sample_index] = 1'b1;
          if (it.final_channel) begin
            res.mixed_sample = mixed;
            res.out_index    = it.sample_index;
            res.block_end    = (it.sample_index == NSAMP - 1);
            return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // -------------------------------------------------------------------------
  // Item builders
  // -------------------------------------------------------------------------
  function automatic in_item_t make_item(input logic [1:0] cmd, input int ch,
                                         input logic [31:0] gain, input logic [15:0] smp,
                                         input int idx, input bit is_first, input bit is_last);
    in_item_t it;
    it.cmd           = cmd;
    it.channel       = 4'(ch);
    it.target_gain   = gain;
    it.sample        = smp;
    it.sample_index  = 7'(idx);
    it.first_channel = is_first;
    it.final_channel = is_last;
    return it;
  endfunction

  function automatic out_item_t mix_result(input int v, input int idx, input bit at_end);
    out_item_t r;
    r.mixed_sample = 16'(v);
    r.out_index    = 7'(idx);
    r.block_end    = at_end;
    return r;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly within four times unity either side of zero so the mix stays interesting, sometimes anywhere
  function automatic logic [31:0] rand_gain();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 8 * UnityGain)) - 4 * UnityGain);
  endfunction

  // -------------------------------------------------------------------------
  // Sender. Valid is held with a stable payload until the item is taken; the
  // idle decision never looks at stall. At most one update of valid per edge.
  // -------------------------------------------------------------------------
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    bit        has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    has = predict_mix(it, res);
    // typed rows carry their own expectation; the predictor still tracks state
    if (typed) expected_mix.push_back(want);
    else if (has) expected_mix.push_back(res);
    if (it.cmd == CMD_TICK ||
        ((it.cmd == CMD_SET_TARGET || it.cmd == CMD_SAMPLE) && it.channel < NCH))
      live_items++;
  endtask

  // sender pauses until every expected item has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_mix.size() != 0) @(posedge clk_i);
  endtask

  // One mixing pass over a short run of positions: every present channel in a
  // rotated order, first flag on the first present one, final on the last.
  task automatic mix_block();
    logic [3:0] present;
    int         span, base, rot, ch, count, seen;
    present = 4'($urandom_range(1, 15));
    count   = $countones(present);
    span    = $urandom_range(1, 6);
    base    = ($urandom_range(3) == 0) ? NSAMP - span : $urandom_range(0, NSAMP - span);
    rot     = $urandom_range(0, NCH - 1);
    for (int i = base; i < base + span; i++) begin
      seen = 0;
      for (int k = 0; k < NCH; k++) begin
        ch = (rot + k) % NCH;
        if (present[ch]) begin
          seen++;
          push_item(make_item(CMD_SAMPLE, ch, $urandom, rand_sample(), i,
                              seen == 1, seen == count), 1'b0, '0);
        end
      end
    end
  endtask

  // Random traffic: mostly well-formed mixing passes, with gain updates,
  // ticks and some noise in between.
  task automatic random_phase(input int goal);
    int r, idx;
    bit fst;
    while (live_items < goal) begin
      r = $urandom_range(99);
      if (r < 66) begin
        mix_block();
      end else if (r < 78) begin
        push_item(make_item(CMD_SET_TARGET, $urandom_range(0, NCH - 1), rand_gain(),
                            16'($urandom), $urandom_range(127), $urandom_range(1),
                            $urandom_range(1)), 1'b0, '0);
      end else if (r < 88) begin
        push_item(make_item(CMD_TICK, $urandom_range(15), $urandom, 16'($urandom),
                            $urandom_range(127), $urandom_range(1), $urandom_range(1)),
                  1'b0, '0);
      end else begin
        case ($urandom_range(2))
          0: push_item(make_item(CmdUnused, $urandom_range(15), $urandom, 16'($urandom),
                                 $urandom_range(127), $urandom_range(1), $urandom_range(1)),
                       1'b0, '0);
          1: push_item(make_item($urandom_range(1) ? CMD_SET_TARGET : CMD_SAMPLE,
                                 $urandom_range(NCH, 15), $urandom, 16'($urandom),
                                 $urandom_range(127), $urandom_range(1), $urandom_range(1)),
                       1'b0, '0);
          default: begin
            // lone sample; adding is only allowed onto an entry already written
            idx = $urandom_range(0, NSAMP - 1);
            fst = mix_written[idx] ? bit'($urandom_range(1)) : 1'b1;
            push_item(make_item(CMD_SAMPLE, $urandom_range(0, NCH - 1), $urandom,
                                rand_sample(), idx, fst, $urandom_range(1)), 1'b0, '0);
          end
        endcase
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver and checker
  // -------------------------------------------------------------------------
  task automatic flag_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic check_mix(input out_item_t got);
    out_item_t want;
    if (expected_mix.size() == 0) begin
      flag_failure($sformatf("unexpected item: mix %0d index %0d end %0d",
                             got.mixed_sample, got.out_index, got.block_end));
    end else begin
      want = expected_mix.pop_front();
      if (got.mixed_sample !== want.mixed_sample || got.out_index !== want.out_index ||
          got.block_end !== want.block_end)
        flag_failure($sformatf("mismatch: expected mix %0d index %0d end %0d, got %0d %0d %0d",
                               want.mixed_sample, want.out_index, want.block_end,
                               got.mixed_sample, got.out_index, got.block_end));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_mix(out_item_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // -------------------------------------------------------------------------
  // Directed table
  // -------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(input in_item_t it, input bit typed, input out_item_t want);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed.push_back(row);
  endtask

  task automatic build_table();
    // unity gain after reset: samples pass straight through; top position ends the block
    add_row(make_item(CMD_SAMPLE, 0, 0, 16'h7fff, NSAMP - 1, 1, 1), 1, mix_result(32767, 127, 1));
    add_row(make_item(CMD_SAMPLE, 1, 0, 16'h8000, 0, 1, 1), 1, mix_result(-32768, 0, 0));
    // positive and negative saturation of the sum
    add_row(make_item(CMD_SAMPLE, 0, 0, 16'h7fff, 5, 1, 0), 0, '0);
    add_row(make_item(CMD_SAMPLE, 1, 0, 16'h7fff, 5, 0, 1), 1, mix_result(32767, 5, 0));
    add_row(make_item(CMD_SAMPLE, 2, 0, 16'h8000, 6, 1, 0), 0, '0);
    add_row(make_item(CMD_SAMPLE, 3, 0, 16'h8000, 6, 0, 1), 1, mix_result(-32768, 6, 0));
    // ignored: unused command, channels past the last one
    add_row(make_item(CmdUnused, 15, '1, '1, 127, 1, 1), 0, '0);
    add_row(make_item(CMD_SET_TARGET, 9, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_SAMPLE, 12, 0, 16'h1234, 6, 1, 1), 0, '0);
    // entry 6 must still hold the saturated low value
    add_row(make_item(CMD_SAMPLE, 3, 0, 16'd100, 6, 0, 1), 1, mix_result(-32668, 6, 0));
    add_row(make_item(CMD_SAMPLE, 0, 0, 16'd0, 20, 1, 1), 1, mix_result(0, 20, 0));
    // target extremes, a target just past unity (step clamps) and zero
    add_row(make_item(CMD_SET_TARGET, 0, GainMax, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_SET_TARGET, 1, GainMin, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_SET_TARGET, 2, UnityGain + 100, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_SET_TARGET, 3, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_SAMPLE, 2, 0, 16'h7fff, 30, 1, 1), 0, '0);
    add_row(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_SAMPLE, 0, 0, 16'h7fff, 31, 1, 0), 0, '0);
    add_row(make_item(CMD_SAMPLE, 1, 0, 16'hffff, 31, 0, 1), 0, '0);
    add_row(make_item(CMD_SAMPLE, 3, 0, 16'h8000, 32, 1, 1), 0, '0);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < NCH; c++) begin
      cur_gain[c] = UnityGain;
      tgt_gain[c] = UnityGain;
    end
    build_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) push_item(directed[i].item, directed[i].typed, directed[i].want);
    settle();

    // random phases: no idling, sender idle, receiver stalling, both
    live_items = 0;
    send_idle_pct = 0;  stall_pct = 0;  random_phase(170); settle();
    send_idle_pct = 87; stall_pct = 0;  random_phase(340); settle();
    send_idle_pct = 0;  stall_pct = 87; random_phase(510); settle();
    send_idle_pct = 19; stall_pct = 19; random_phase(680); settle();

    // Large gains: targets at the range limits, then a run of ticks ramps
    // channels 0 and 1 toward them before mixing.
    send_idle_pct = 0; stall_pct = 19;
    push_item(make_item(CMD_SET_TARGET, 0, GainMax, 0, 0, 0, 0), 0, '0);
    push_item(make_item(CMD_SET_TARGET, 1, GainMin, 0, 0, 0, 0), 0, '0);
    repeat (24) push_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0), 0, '0);
    repeat (12) mix_block();

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_mix.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
